[rtl/core/echo_pulse_ranger_avg5_core_defines.svh]
// ----------------------------------------------------------------------------
// echo_pulse_ranger_avg5_core_defines.svh
// Assertion macros used by the echo ranger queue.
// ----------------------------------------------------------------------------
`ifndef ECHO_PULSE_RANGER_AVG5_CORE_DEFINES_SVH
`define ECHO_PULSE_RANGER_AVG5_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define EPR_ASSERT(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("echo ranger check failed");
// Clocked implication from one cycle to the next, disabled in reset.
`define EPR_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("echo ranger check failed");
`else
`define EPR_ASSERT(lbl, clk, rstn, expr)
`define EPR_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

[rtl/core/epravg_pkg.sv]
// ----------------------------------------------------------------------------
// epravg_pkg
// Constants and types shared by the echo ranger front, queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epravg_pkg;

	localparam int WINDOW_LEN = 5;
	localparam int COUNT_BITS = 16;
	localparam int HIST_LEN   = WINDOW_LEN - 1;

	localparam int MM_BITS    = 16;
	localparam int SCALE_BITS = 16;
	localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd11380;

	// product of tick count and Q0.16 scale
	localparam int PROD_BITS  = COUNT_BITS + SCALE_BITS;

	// window sum and reciprocal divide by WINDOW_LEN
	localparam int SUM_BITS   = MM_BITS + $clog2(WINDOW_LEN);
	localparam int DIV_SHIFT  = SUM_BITS + 4;
	localparam logic [DIV_SHIFT-1:0] DIV_RECIP =
		DIV_SHIFT'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
	localparam int QUOT_BITS  = SUM_BITS + DIV_SHIFT;

	// queue between front and back end, depth a power of two
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = QPTR_BITS + 1;

	typedef struct packed {
		logic                  push;
		logic [COUNT_BITS-1:0] ticks;
	} q_wr_t;

	typedef struct packed {
		logic                  valid;
		logic [COUNT_BITS-1:0] ticks;
	} q_rd_t;

endpackage

`default_nettype wire

[rtl/core/echo_pulse_ranger_avg5_core.sv]
// Echo pulse ranger with a five-sample moving average.
//
// Slave stream: one transfer per timer tick, s_tdata[0] is the sampled echo
// level. A rising edge restarts the pulse count, high ticks extend it (the
// count clamps at its top), a falling edge finishes the pulse.
// Master stream: one transfer per finished pulse with the distance in mm and
// the mean of the last five distances, the fraction dropped.
// Configuration: cfg_we writes cfg_wdata as the Q0.16 mm-per-tick scale.
//
// Throughput: one tick per cycle while the count queue has room; a finished
// count is scaled in one multiply stage and the mean comes from a running
// window sum and a reciprocal multiply, so the back end is pipelined and
// takes a new count before earlier results leave. Path: a result passes the
// count queue and stages s1, s2 and s3 before it appears on m_tvalid.
// Stall: a four-entry count queue and the three back-end stages absorb
// results while m_tready is low; once the queue is full s_tready drops.
// Reset: the scale returns to 11380, the window and counter clear, and the
// queue and pipeline empty.
// ----------------------------------------------------------------------------
// echo_pulse_ranger_avg5_core
// Top level: front edge tracker, count queue, scaling and averaging back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module echo_pulse_ranger_avg5_core
	import epravg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [0] echo_level
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [31:0]                m_tdata,   // [15:0] raw_mm, [31:16] average_mm
	input  wire logic                  cfg_we,
	input  wire logic [SCALE_BITS-1:0] cfg_wdata
);

	q_wr_t              q_wr;
	q_rd_t              q_rd;
	logic               q_full;
	logic               q_pop;
	logic [MM_BITS-1:0] raw_mm;
	logic [MM_BITS-1:0] average_mm;

	epravg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.echo_level (s_tdata[0]),
		.q_full     (q_full),
		.q_wr       (q_wr)
	);

	epravg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_rd   (q_rd),
		.q_pop  (q_pop)
	);

	epravg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_rd       (q_rd),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.raw_mm     (raw_mm),
		.average_mm (average_mm)
	);

	assign m_tdata = {average_mm, raw_mm};

endmodule

`default_nettype wire

[rtl/core/epravg_front.sv]
// ----------------------------------------------------------------------------
// epravg_front
// Tracks echo edges, counts pulse length and hands finished counts on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epravg_front
	import epravg_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	input  wire logic  echo_level,
	input  wire logic  q_full,
	output q_wr_t      q_wr
);

	logic                  echo_prev_q;
	logic [COUNT_BITS-1:0] ticks_q;
	logic                  take;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	// falling edge: transfer the finished count to the queue
	assign q_wr.push  = take && !echo_level && echo_prev_q;
	assign q_wr.ticks = ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_prev_q <= 1'b0;
			ticks_q     <= '0;
		end else if (take) begin
			echo_prev_q <= echo_level;
			if (echo_level && !echo_prev_q) begin
				ticks_q <= COUNT_BITS'(1);
			end else if (echo_level && (ticks_q != '1)) begin
				ticks_q <= ticks_q + COUNT_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/epravg_queue.sv]
// ----------------------------------------------------------------------------
// epravg_queue
// Short queue of pulse counts between the front and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "echo_pulse_ranger_avg5_core_defines.svh"

module epravg_queue
	import epravg_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire q_wr_t q_wr,
	output logic       q_full,
	output q_rd_t      q_rd,
	input  wire logic  q_pop
);

	logic [COUNT_BITS-1:0] entry_q [QDEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QCNT_BITS-1:0]  count_q;
	logic                  do_pop;

	assign q_full     = (count_q == QCNT_BITS'(QDEPTH));
	assign q_rd.valid = (count_q != '0);
	assign q_rd.ticks = entry_q[rd_ptr_q];
	assign do_pop     = q_pop && q_rd.valid;

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			entry_q[wr_ptr_q] <= q_wr.ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			case ({q_wr.push, do_pop})
				2'b10:   count_q <= count_q + QCNT_BITS'(1);
				2'b01:   count_q <= count_q - QCNT_BITS'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`EPR_ASSERT(a_no_push_full, clk, arst_n, !(q_wr.push && q_full))
	`EPR_ASSERT(a_ptr_count, clk, arst_n, count_q[QPTR_BITS-1:0] == (wr_ptr_q - rd_ptr_q))
	`EPR_ASSERT_NEXT(a_pop_drains, clk, arst_n, do_pop && !q_wr.push,
		count_q == $past(count_q) - QCNT_BITS'(1))

endmodule

`default_nettype wire

[rtl/core/epravg_back.sv]
// ----------------------------------------------------------------------------
// epravg_back
// Scales pulse counts to millimetres and forms the moving average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epravg_back
	import epravg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [SCALE_BITS-1:0] cfg_wdata,
	input  wire q_rd_t                 q_rd,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [MM_BITS-1:0]         raw_mm,
	output logic [MM_BITS-1:0]         average_mm
);

	logic [SCALE_BITS-1:0] scale_q;

	logic                  vld_s1, vld_s2, vld_s3;
	logic                  adv_s1, adv_s2, adv_s3;
	logic [PROD_BITS-1:0]  prod_s1;
	logic [MM_BITS-1:0]    raw_s2, raw_s3;
	logic [SUM_BITS-1:0]   sum_s2;
	logic [QUOT_BITS-1:0]  quot_s3;

	logic [MM_BITS-1:0]    hist_q [HIST_LEN];
	logic [SUM_BITS-1:0]   hsum_q;

	logic [PROD_BITS-1:0]  mm_wide;
	logic [MM_BITS-1:0]    raw_sat;
	logic                  load_s2;

	// advance a stage when it is empty or its successor moves
	assign adv_s3 = !vld_s3 || m_tready;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign q_pop  = adv_s1 && q_rd.valid;
	assign load_s2 = adv_s2 && vld_s1;

	// drop the fraction, clamp at the top of the output range
	assign mm_wide = prod_s1 >> SCALE_BITS;
	assign raw_sat = (mm_wide > PROD_BITS'({MM_BITS{1'b1}})) ? '1 : mm_wide[MM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= q_rd.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_s1 <= PROD_BITS'(q_rd.ticks) * PROD_BITS'(scale_q);
		end
		if (load_s2) begin
			raw_s2 <= raw_sat;
			sum_s2 <= hsum_q + SUM_BITS'(raw_sat);
		end
		if (adv_s3 && vld_s2) begin
			raw_s3  <= raw_s2;
			quot_s3 <= QUOT_BITS'(sum_s2) * QUOT_BITS'(DIV_RECIP);
		end
	end

	// window history and its running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST_LEN; i++) begin
				hist_q[i] <= '0;
			end
			hsum_q <= '0;
		end else if (load_s2) begin
			for (int i = 0; i < HIST_LEN - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[HIST_LEN-1] <= raw_sat;
			hsum_q <= hsum_q + SUM_BITS'(raw_sat) - SUM_BITS'(hist_q[0]);
		end
	end

	assign m_tvalid   = vld_s3;
	assign raw_mm     = raw_s3;
	assign average_mm = quot_s3[DIV_SHIFT +: MM_BITS];

endmodule

`default_nettype wire
